[src/mfc_pkg.sv]
// ----------------------------------------------------------------------------
// mfc_pkg
// shared types and constants of the multichannel fir convolver
// ----------------------------------------------------------------------------
package mfc_pkg;

   // field widths of the request, response and csr channels
   localparam int CMD_W      = 1;
   localparam int CH_FIELD_W = 3;
   localparam int SAMPLE_W   = 16;
   localparam int TAP_IDX_W  = 8;
   localparam int COUNT_W    = 9;

   // defaults of the top level parameters
   localparam int TAPS_DEFAULT     = 256;
   localparam int CHANNELS_DEFAULT = 8;

   // tap count after reset
   localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

   // q1.15 arithmetic
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int FRAC_W     = 15;
   localparam int ROUND_BIAS = 16384;
   localparam int SAT_MAX    = 32767;
   localparam int SAT_MIN    = -32768;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 1'b0,
      CMD_LOAD   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_DONE
   } back_state_type;

   // one classified request waiting for the back end
   typedef struct packed {
      cmd_type                     kind;
      logic [CH_FIELD_W-1:0]       channel;
      logic signed [SAMPLE_W-1:0]  data;
      logic [TAP_IDX_W-1:0]        tap_index;
   } queue_entry_type;

   // back end handshake events
   typedef struct packed {
      logic pop;
      logic out_load;
   } back_status_type;

endpackage

[src/mfc_ifs.sv]
// ----------------------------------------------------------------------------
// mfc channel interfaces
// request, response and csr write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mfc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [mfc_pkg::CMD_W-1:0]                 cmd;
   logic [mfc_pkg::CH_FIELD_W-1:0]            channel;
   logic signed [mfc_pkg::SAMPLE_W-1:0]       sample_in;
   logic [mfc_pkg::TAP_IDX_W-1:0]             tap_index;
   logic signed [mfc_pkg::SAMPLE_W-1:0]       tap_value;

   modport source (output valid, cmd, channel, sample_in, tap_index, tap_value,
                   input ready);
   modport sink (input valid, cmd, channel, sample_in, tap_index, tap_value,
                 output ready);
endinterface

interface mfc_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mfc_pkg::SAMPLE_W-1:0]       sample_out;
   logic [mfc_pkg::CH_FIELD_W-1:0]            out_channel;

   modport source (output valid, sample_out, out_channel, input ready);
   modport sink (input valid, sample_out, out_channel, output ready);
endinterface

interface mfc_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic [mfc_pkg::COUNT_W-1:0]               tap_count;

   modport source (output valid, tap_count, input ready);
   modport sink (input valid, tap_count, output ready);
endinterface

[src/multichannel_fir_convolver.sv]
// ----------------------------------------------------------------------------
// multichannel_fir_convolver: per-channel fir filter with one shared response
// a sample runs the shared mac over the n taps in use, n = clamped tap count
// the back end takes no new sample or load until the last response is loaded
// tap loads retire one per cycle while the back end is idle; reset is synchronous, stores read as zero
// ----------------------------------------------------------------------------
module multichannel_fir_convolver #(
   parameter int TAPS     = mfc_pkg::TAPS_DEFAULT,
   parameter int CHANNELS = mfc_pkg::CHANNELS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mfc_req_if.sink      req_bus,
   mfc_rsp_if.source    rsp_bus,
   mfc_csr_if.sink      csr_bus
);

   // tap_index reaches only the first 256 taps; later ones stay zero,
   // so the tap store and each channel's history ring hold at most 256 entries
   localparam int TAP_SPAN  = 2 ** mfc_pkg::TAP_IDX_W;
   localparam int TAP_DEPTH = (TAPS < TAP_SPAN) ? TAPS : TAP_SPAN;
   // the channel field addresses at most eight channels
   localparam int CH_SPAN   = 2 ** mfc_pkg::CH_FIELD_W;
   localparam int CH_DEPTH  = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;

   logic [mfc_pkg::COUNT_W-1:0] tap_count_ff, tap_count_in;

   logic                        q_push;
   logic                        q_full;
   logic                        q_valid;
   mfc_pkg::queue_entry_type    push_entry;
   mfc_pkg::queue_entry_type    head_entry;
   mfc_pkg::back_status_type    status;

   // csr: tap count register, always ready; the user must write it only while idle, unchecked by the block
   assign csr_bus.ready = 1'b1;
   assign tap_count_in  = (csr_bus.valid && csr_bus.ready) ? csr_bus.tap_count
                                                            : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= mfc_pkg::TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // front: takes each request, drops loads past the tap store and
   // samples of channels that do not exist
   mfc_front #(
      .TAP_DEPTH (TAP_DEPTH),
      .CH_DEPTH  (CH_DEPTH)
   ) u_front (
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   // short queue so the front keeps taking requests while the mac runs
   mfc_queue #(
      .DEPTH (mfc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (status.pop),
      .valid      (q_valid),
      .head_entry (head_entry)
   );

   // back: writes taps, pushes samples into the history ring, runs the
   // mac over the taps in use, rounds, saturates and holds the response
   mfc_back #(
      .TAP_DEPTH (TAP_DEPTH),
      .CH_DEPTH  (CH_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tap_count (tap_count_ff),
      .q_valid   (q_valid),
      .q_entry   (head_entry),
      .status    (status),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   // the front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue overflow");

   // the back only pops a waiting request
   assert property (@(posedge clock) disable iff (reset) status.pop |-> q_valid)
      else $error("pop from empty queue");

   // a new response never overwrites one that is not taken
   assert property (@(posedge clock) disable iff (reset)
      status.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response overwritten");

   // a loaded response shows on the port in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      status.out_load |=> rsp_bus.valid)
      else $error("response lost");
`endif

endmodule

[src/mfc_ram.sv]
// ----------------------------------------------------------------------------
// mfc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mfc_front.sv]
// ----------------------------------------------------------------------------
// mfc_front
// accepts requests, drops out-of-range ones, builds queue entries
// ----------------------------------------------------------------------------
module mfc_front #(
   parameter int TAP_DEPTH = 256,
   parameter int CH_DEPTH  = 8
) (
   mfc_req_if.sink                     req_bus,
   input  logic                        q_full,
   output logic                        q_push,
   output mfc_pkg::queue_entry_type    q_entry
);

   localparam int IDX_CMP_W = mfc_pkg::TAP_IDX_W + 1;
   localparam int CH_CMP_W  = mfc_pkg::CH_FIELD_W + 1;

   logic accept;
   logic is_load;
   logic idx_ok;
   logic ch_ok;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_load       = (req_bus.cmd == mfc_pkg::CMD_LOAD);

   // a load beyond the tap store or a sample of a missing channel has no effect
   assign idx_ok = ({1'b0, req_bus.tap_index} < IDX_CMP_W'(TAP_DEPTH));
   assign ch_ok  = ({1'b0, req_bus.channel} < CH_CMP_W'(CH_DEPTH));

   assign q_push = accept && (is_load ? idx_ok : ch_ok);

   always_comb begin
      q_entry.kind      = mfc_pkg::cmd_type'(req_bus.cmd);
      q_entry.channel   = req_bus.channel;
      q_entry.data      = is_load ? req_bus.tap_value : req_bus.sample_in;
      q_entry.tap_index = req_bus.tap_index;
   end

endmodule

[src/mfc_queue.sv]
// ----------------------------------------------------------------------------
// mfc_queue
// short fifo between front and back end
// ----------------------------------------------------------------------------
module mfc_queue #(
   parameter int DEPTH = mfc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mfc_pkg::queue_entry_type    push_entry,
   output logic                        full,
   input  logic                        pop,
   output logic                        valid,
   output mfc_pkg::queue_entry_type    head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mfc_pkg::queue_entry_type ent_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign valid      = (cnt_ff != '0);
   assign head_entry = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[src/mfc_back.sv]
// ----------------------------------------------------------------------------
// mfc_back
// tap and history stores, shared multiply-accumulate, output register
// ----------------------------------------------------------------------------
module mfc_back #(
   parameter int TAP_DEPTH = 256,
   parameter int CH_DEPTH  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mfc_pkg::COUNT_W-1:0]          tap_count,
   input  logic                                 q_valid,
   input  mfc_pkg::queue_entry_type             q_entry,
   output mfc_pkg::back_status_type             status,
   mfc_rsp_if.source                            rsp_bus
);

   localparam int POS_W      = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
   localparam int LEN_W      = $clog2(TAP_DEPTH + 1);
   localparam int CH_W       = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
   localparam int HIST_DEPTH = CH_DEPTH * (2 ** POS_W);
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int ACC_W      = mfc_pkg::PROD_W + POS_W + 1;
   localparam int SW         = mfc_pkg::SAMPLE_W;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(mfc_pkg::SAT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(mfc_pkg::SAT_MIN);

   mfc_pkg::back_state_type state_ff, state_in;

   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         fill_sel_ff, fill_sel_in;
   logic [POS_W-1:0]         k_ff, k_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [POS_W-1:0]         head_ff [CH_DEPTH];
   logic [POS_W-1:0]         head_in [CH_DEPTH];
   logic [LEN_W-1:0]         fill_ff [CH_DEPTH];
   logic [LEN_W-1:0]         fill_in [CH_DEPTH];
   logic [TAP_DEPTH-1:0]     tap_vld_ff, tap_vld_in;

   logic                     s1_vld_ff, s1_vld_in;
   logic                     s1_last_ff, s1_last_in;
   logic                     s1_hok_ff, s1_hok_in;
   logic                     s1_tok_ff, s1_tok_in;
   logic                     s2_vld_ff;
   logic                     s2_last_ff;
   logic signed [mfc_pkg::PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   logic                     rsp_vld_ff, rsp_vld_in;
   logic signed [SW-1:0]     rsp_data_ff, rsp_data_in;
   logic [mfc_pkg::CH_FIELD_W-1:0] rsp_ch_ff, rsp_ch_in;

   logic [CH_W-1:0]          ch_sel;
   logic [POS_W-1:0]         head_cur, head_nxt;
   logic [LEN_W-1:0]         fill_cur, fill_nxt;
   logic [LEN_W-1:0]         len_calc;
   logic [POS_W-1:0]         tap_addr;
   logic                     iss;
   logic                     iss_last;
   logic                     pop;
   logic                     out_load;
   logic                     tap_we;
   logic                     hist_we;
   logic [SW-1:0]            tap_rd;
   logic [SW-1:0]            hist_rd;
   logic signed [SW-1:0]     tap_term, hist_term;
   logic signed [ACC_W-1:0]  rnd_val, q_val;
   logic signed [SW-1:0]     sat_val;

   // per-channel ring position and fill level of the selected channel
   assign ch_sel   = CH_W'(q_entry.channel);
   assign head_cur = head_ff[ch_sel];
   assign head_nxt = (head_cur == POS_W'(TAP_DEPTH - 1)) ? '0 : head_cur + 1'b1;
   assign fill_cur = fill_ff[ch_sel];
   assign fill_nxt = (fill_cur == LEN_W'(TAP_DEPTH)) ? fill_cur : fill_cur + 1'b1;
   assign tap_addr = POS_W'(q_entry.tap_index);

   // taps in use, clamped to 1..TAP_DEPTH
   always_comb begin
      if (tap_count == '0) begin
         len_calc = LEN_W'(1);
      end else if (tap_count > mfc_pkg::COUNT_W'(TAP_DEPTH)) begin
         len_calc = LEN_W'(TAP_DEPTH);
      end else begin
         len_calc = LEN_W'(tap_count);
      end
   end

   assign iss      = (state_ff == mfc_pkg::ST_MAC);
   assign iss_last = (LEN_W'(k_ff) == len_ff - 1'b1);

   // round half up, then saturate to 16 bits
   assign rnd_val = acc_ff + ACC_W'(mfc_pkg::ROUND_BIAS);
   assign q_val   = rnd_val >>> mfc_pkg::FRAC_W;
   always_comb begin
      if (q_val > SAT_HI) begin
         sat_val = SW'(mfc_pkg::SAT_MAX);
      end else if (q_val < SAT_LO) begin
         sat_val = SW'(mfc_pkg::SAT_MIN);
      end else begin
         sat_val = SW'(q_val);
      end
   end

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      len_in      = len_ff;
      fill_sel_in = fill_sel_ff;
      k_in        = k_ff;
      pos_in      = pos_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      tap_vld_in  = tap_vld_ff;
      pop         = 1'b0;
      out_load    = 1'b0;
      tap_we      = 1'b0;
      hist_we     = 1'b0;
      case (state_ff)
         mfc_pkg::ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               if (q_entry.kind == mfc_pkg::CMD_LOAD) begin
                  tap_we               = 1'b1;
                  tap_vld_in[tap_addr] = 1'b1;
               end else begin
                  hist_we         = 1'b1;
                  head_in[ch_sel] = head_nxt;
                  fill_in[ch_sel] = fill_nxt;
                  ch_in           = ch_sel;
                  len_in          = len_calc;
                  fill_sel_in     = fill_nxt;
                  k_in            = '0;
                  pos_in          = head_nxt;
                  state_in        = mfc_pkg::ST_MAC;
               end
            end
         end
         mfc_pkg::ST_MAC: begin
            k_in   = k_ff + 1'b1;
            pos_in = (pos_ff == '0) ? POS_W'(TAP_DEPTH - 1) : pos_ff - 1'b1;
            if (iss_last) begin
               state_in = mfc_pkg::ST_FLUSH;
            end
         end
         mfc_pkg::ST_FLUSH: begin
            if (s2_vld_ff && s2_last_ff) begin
               state_in = mfc_pkg::ST_DONE;
            end
         end
         mfc_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = mfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfc_pkg::ST_IDLE;
         end
      endcase
   end

   // mac pipeline: address, ram read, multiply, accumulate
   assign s1_vld_in  = iss;
   assign s1_last_in = iss && iss_last;
   assign s1_hok_in  = (LEN_W'(k_ff) < fill_sel_ff);
   assign s1_tok_in  = tap_vld_ff[k_ff];

   assign tap_term   = s1_tok_ff ? $signed(tap_rd) : '0;
   assign hist_term  = s1_hok_ff ? $signed(hist_rd) : '0;
   assign s2_prod_in = tap_term * hist_term;

   always_comb begin
      acc_in = acc_ff;
      if (hist_we) begin
         acc_in = '0;
      end else if (s2_vld_ff) begin
         acc_in = acc_ff + ACC_W'(s2_prod_ff);
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_ch_in   = rsp_ch_ff;
      if (out_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = sat_val;
         rsp_ch_in   = mfc_pkg::CH_FIELD_W'(ch_ff);
      end else if (rsp_bus.ready) begin
         rsp_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mfc_pkg::ST_IDLE;
         tap_vld_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s1_last_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s2_last_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < CH_DEPTH; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         tap_vld_ff <= tap_vld_in;
         s1_vld_ff  <= s1_vld_in;
         s1_last_ff <= s1_last_in;
         s2_vld_ff  <= s1_vld_ff;
         s2_last_ff <= s1_last_ff;
         rsp_vld_ff <= rsp_vld_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      len_ff      <= len_in;
      fill_sel_ff <= fill_sel_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      s1_hok_ff   <= s1_hok_in;
      s1_tok_ff   <= s1_tok_in;
      s2_prod_ff  <= s2_prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ch_ff   <= rsp_ch_in;
   end

   mfc_ram #(
      .WIDTH (SW),
      .DEPTH (TAP_DEPTH)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_we),
      .wr_addr (tap_addr),
      .wr_data (q_entry.data),
      .rd_en   (iss),
      .rd_addr (k_ff),
      .rd_data (tap_rd)
   );

   mfc_ram #(
      .WIDTH (SW),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (HIST_AW'({ch_sel, head_nxt})),
      .wr_data (q_entry.data),
      .rd_en   (iss),
      .rd_addr (HIST_AW'({ch_ff, pos_ff})),
      .rd_data (hist_rd)
   );

   assign status.pop      = pop;
   assign status.out_load = out_load;

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.sample_out  = rsp_data_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel fir convolver testbench
// walks a directed table of tap loads and samples, then random traffic under
// several tap counts, and checks every filtered sample against a predictor or a typed result
// ----------------------------------------------------------------------------
module testbench;

   localparam int  NUM_TAPS          = mfc_pkg::TAPS_DEFAULT;
   localparam int  NUM_CHANNELS      = mfc_pkg::CHANNELS_DEFAULT;
   localparam int  ITEMS_PER_SETTING = 100;
   localparam int  LOAD_DRAIN_CYCLES = 16;   // loads still queued when the last sample returns
   localparam int  END_DRAIN_CYCLES  = 300;  // a little more than one sample at full tap count
   localparam int  NUM_DIRECTED      = 19;
   localparam int  NUM_SETTINGS      = 8;

   // one row of stimulus; known marks rows whose filtered sample is typed in
   typedef struct packed {
      mfc_pkg::cmd_type                    cmd;
      logic [mfc_pkg::CH_FIELD_W-1:0]      channel;
      logic signed [mfc_pkg::SAMPLE_W-1:0] sample_in;
      logic [mfc_pkg::TAP_IDX_W-1:0]       tap_index;
      logic signed [mfc_pkg::SAMPLE_W-1:0] tap_value;
      logic                                known;
      logic signed [mfc_pkg::SAMPLE_W-1:0] known_out;
   } request_row_type;

   typedef struct packed {
      logic signed [mfc_pkg::SAMPLE_W-1:0] sample_out;
      logic [mfc_pkg::CH_FIELD_W-1:0]      out_channel;
   } filtered_type;

   // receiver behavior, picked anew each time the stall tick wraps
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_BLOCK
   } stall_mode_type;

   logic clock;
   logic reset;

   mfc_req_if req_bus ();
   mfc_rsp_if rsp_bus ();
   mfc_csr_if csr_bus ();

   multichannel_fir_convolver DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow state of the filter
   logic signed [mfc_pkg::SAMPLE_W-1:0]  tap_coef    [NUM_TAPS];
   logic signed [mfc_pkg::SAMPLE_W-1:0]  sample_hist [NUM_CHANNELS][NUM_TAPS];
   logic [mfc_pkg::TAP_IDX_W-1:0]        hist_head   [NUM_CHANNELS];
   logic [mfc_pkg::COUNT_W-1:0]          tap_count_shadow;

   // filtered samples still owed by the block, oldest first
   filtered_type pending_outputs [$];

   int mismatch_count    = 0;
   int responses_checked = 0;
   int samples_sent      = 0;
   int loads_sent        = 0;
   int settings_used     = 0;
   int burst_left        = 0;

   // directed table, all rows at the reset tap count of 256
   // typed results hold while only taps 0 and 1 are nonzero
   request_row_type directed_rows [NUM_DIRECTED] = '{
      // all taps zero: silence whatever the input
      '{mfc_pkg::CMD_SAMPLE, 3'd0, 16'sh7FFF, 8'h00, 16'sh0000, 1'b1, 16'sh0000},
      '{mfc_pkg::CMD_LOAD,   3'd0, 16'sh0000, 8'h00, 16'sh7FFF, 1'b0, 16'sh0000},
      // max times max, rounds down to 32766
      '{mfc_pkg::CMD_SAMPLE, 3'd1, 16'sh7FFF, 8'h00, 16'sh0000, 1'b1, 16'sh7FFE},
      '{mfc_pkg::CMD_LOAD,   3'd0, 16'sh0000, 8'h00, 16'sh8000, 1'b0, 16'sh0000},
      // min times min overflows, saturates high
      '{mfc_pkg::CMD_SAMPLE, 3'd2, 16'sh8000, 8'h00, 16'sh0000, 1'b1, 16'sh7FFF},
      // min times max, exact at one lsb above the minimum
      '{mfc_pkg::CMD_SAMPLE, 3'd3, 16'sh7FFF, 8'h00, 16'sh0000, 1'b1, 16'sh8001},
      '{mfc_pkg::CMD_LOAD,   3'd0, 16'sh0000, 8'h01, 16'sh8000, 1'b0, 16'sh0000},
      // two full negative products, saturates low
      '{mfc_pkg::CMD_SAMPLE, 3'd3, 16'sh7FFF, 8'h00, 16'sh0000, 1'b1, 16'sh8000},
      '{mfc_pkg::CMD_LOAD,   3'd0, 16'sh0000, 8'h00, 16'sh0001, 1'b0, 16'sh0000},
      '{mfc_pkg::CMD_LOAD,   3'd0, 16'sh0000, 8'h01, 16'sh0000, 1'b0, 16'sh0000},
      // exact ties: +0.5 lsb goes to 1, -0.5 lsb goes to 0, just below goes to -1
      '{mfc_pkg::CMD_SAMPLE, 3'd4, 16'sh4000, 8'h00, 16'sh0000, 1'b1, 16'sh0001},
      '{mfc_pkg::CMD_SAMPLE, 3'd5, 16'shC000, 8'h00, 16'sh0000, 1'b1, 16'sh0000},
      '{mfc_pkg::CMD_SAMPLE, 3'd6, 16'shBFFF, 8'h00, 16'sh0000, 1'b1, 16'shFFFF},
      // last tap position, channel and sample fields of a load are don't-care
      '{mfc_pkg::CMD_LOAD,   3'd5, 16'sh55AA, 8'hFF, 16'sh8000, 1'b0, 16'sh0000},
      // tap fields of a sample are don't-care
      '{mfc_pkg::CMD_SAMPLE, 3'd6, 16'sh1234, 8'h5A, 16'sh7FFF, 1'b0, 16'sh0000},
      '{mfc_pkg::CMD_LOAD,   3'd7, 16'shFFFF, 8'h80, 16'sh5A5A, 1'b0, 16'sh0000},
      '{mfc_pkg::CMD_SAMPLE, 3'd0, 16'sh8000, 8'hAA, 16'sh1234, 1'b0, 16'sh0000},
      '{mfc_pkg::CMD_LOAD,   3'd2, 16'sh0F0F, 8'hFF, 16'sh7FFF, 1'b0, 16'sh0000},
      '{mfc_pkg::CMD_SAMPLE, 3'd7, 16'sh0001, 8'h00, 16'sh0000, 1'b0, 16'sh0000}
   };

   // tap counts of the random phases: 0 and above 256 are clamped by the block
   logic [mfc_pkg::COUNT_W-1:0] tap_count_plan [NUM_SETTINGS] = '{
      9'd1, 9'd0, 9'd511, 9'd2, 9'd255, 9'd256, 9'd17, 9'd40
   };

   // receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   logic [5:0]     stall_tick = '0;

   // ------------------------------------------------------------------------
   // clock and timeout
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // shift one sample into its channel and return the rounded, saturated sum
   function automatic logic signed [mfc_pkg::SAMPLE_W-1:0] filter_sample(
      input logic [mfc_pkg::CH_FIELD_W-1:0]      ch,
      input logic signed [mfc_pkg::SAMPLE_W-1:0] x
   );
      int                            n;
      longint                        acc;
      logic [mfc_pkg::TAP_IDX_W-1:0] head;
      logic [mfc_pkg::TAP_IDX_W-1:0] pos;
      n = int'(tap_count_shadow);
      if (n < 1) n = 1;
      if (n > NUM_TAPS) n = NUM_TAPS;
      // 8-bit head wraps at the history depth
      head = hist_head[ch] + 1'b1;
      hist_head[ch] = head;
      sample_hist[ch][head] = x;
      acc = 0;
      for (int k = 0; k < n; k++) begin
         pos = head - mfc_pkg::TAP_IDX_W'(k);
         acc += longint'(tap_coef[k]) * longint'(sample_hist[ch][pos]);
      end
      // round half up, then arithmetic shift is a floor
      acc = (acc + mfc_pkg::ROUND_BIAS) >>> mfc_pkg::FRAC_W;
      if (acc > mfc_pkg::SAT_MAX) acc = mfc_pkg::SAT_MAX;
      if (acc < mfc_pkg::SAT_MIN) acc = mfc_pkg::SAT_MIN;
      return mfc_pkg::SAMPLE_W'(acc);
   endfunction

   // random q1.15 value leaning on extremes and small magnitudes
   function automatic logic signed [mfc_pkg::SAMPLE_W-1:0] pick_q15();
      logic signed [mfc_pkg::SAMPLE_W-1:0] v;
      v = mfc_pkg::SAMPLE_W'($urandom);
      case ($urandom_range(0, 3))
         0: v = v >>> $urandom_range(4, 12);
         1: begin
            case ($urandom_range(0, 4))
               0: v = 16'sh7FFF;
               1: v = 16'sh8000;
               2: v = 16'sh0000;
               3: v = 16'sh0001;
               default: v = 16'shFFFF;
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------

   // sender works in bursts; between them a random gap may drop valid
   task automatic drive_request(input request_row_type row);
      int           gap;
      filtered_type owed;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= row.cmd;
      req_bus.channel   <= row.channel;
      req_bus.sample_in <= row.sample_in;
      req_bus.tap_index <= row.tap_index;
      req_bus.tap_value <= row.tap_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // request taken at this edge: update the shadow state
      if (row.cmd == mfc_pkg::CMD_LOAD) begin
         tap_coef[row.tap_index] = row.tap_value;
         loads_sent++;
      end else begin
         owed.out_channel = row.channel;
         owed.sample_out  = filter_sample(row.channel, row.sample_in);
         if (row.known) owed.sample_out = row.known_out;
         pending_outputs.push_back(owed);
         samples_sent++;
      end
   endtask

   // block is idle once every sample is back and trailing loads have retired
   task automatic wait_idle(input int drain_cycles);
      req_bus.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (drain_cycles) @(posedge clock);
   endtask

   task automatic write_tap_count(input logic [mfc_pkg::COUNT_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.tap_count <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid    <= 1'b0;
      tap_count_shadow  = value;
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // response side: stall pattern and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_tick == '0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      stall_tick <= stall_tick + 1'b1;
      case (stall_mode)
         STALL_NONE:   rsp_bus.ready <= 1'b1;
         STALL_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_bus.ready <= (stall_tick[1:0] == 2'd3);
         default:      rsp_bus.ready <= (stall_tick[5:4] != 2'd0);
      endcase
   end

   always @(posedge clock) begin
      filtered_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected response: sample_out %0d out_channel %0d",
                   rsp_bus.sample_out, rsp_bus.out_channel);
            mismatch_count++;
         end else begin
            owed = pending_outputs.pop_front();
            responses_checked++;
            if (rsp_bus.sample_out !== owed.sample_out) begin
               $error("sample_out: expected %0d, actual %0d",
                      owed.sample_out, rsp_bus.sample_out);
               mismatch_count++;
            end
            if (rsp_bus.out_channel !== owed.out_channel) begin
               $error("out_channel: expected %0d, actual %0d",
                      owed.out_channel, rsp_bus.out_channel);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      request_row_type row;
      int              live_taps;

      // request and csr inputs known from time zero
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= mfc_pkg::CMD_SAMPLE;
      req_bus.channel   <= '0;
      req_bus.sample_in <= '0;
      req_bus.tap_index <= '0;
      req_bus.tap_value <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.tap_count <= '0;

      // shadow state after reset
      foreach (tap_coef[i]) tap_coef[i] = '0;
      foreach (sample_hist[c, i]) sample_hist[c][i] = '0;
      foreach (hist_head[c]) hist_head[c] = '0;
      tap_count_shadow = mfc_pkg::TAP_COUNT_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset tap count
      foreach (directed_rows[i]) drive_request(directed_rows[i]);

      // random phases, one tap count each, written while the block is idle
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         wait_idle(LOAD_DRAIN_CYCLES);
         if (p == NUM_SETTINGS - 1)
            write_tap_count(mfc_pkg::COUNT_W'($urandom_range(3, 64)));
         else
            write_tap_count(tap_count_plan[p]);
         live_taps = int'(tap_count_shadow);
         if (live_taps < 1) live_taps = 1;
         if (live_taps > NUM_TAPS) live_taps = NUM_TAPS;

         for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
            row           = '0;
            row.cmd       = ($urandom_range(0, 9) < 3) ? mfc_pkg::CMD_LOAD
                                                       : mfc_pkg::CMD_SAMPLE;
            // at least half the samples on channel 0 so its history wraps around
            row.channel   = ($urandom_range(0, 1) == 0)
                            ? '0
                            : mfc_pkg::CH_FIELD_W'($urandom);
            row.sample_in = pick_q15();
            // loads mostly land on taps that are in use
            row.tap_index = ($urandom_range(0, 3) == 0)
                            ? mfc_pkg::TAP_IDX_W'($urandom)
                            : mfc_pkg::TAP_IDX_W'($urandom_range(0, live_taps - 1));
            row.tap_value = pick_q15();
            drive_request(row);
         end
      end

      wait_idle(END_DRAIN_CYCLES);

      $display("covered %0d samples and %0d tap loads over %0d tap-count settings",
               samples_sent, loads_sent, settings_used + 1);
      $display("%0d filtered samples compared, %0d mismatches",
               responses_checked, mismatch_count);
      if (mismatch_count == 0 && pending_outputs.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
src/mfc_pkg.sv
src/mfc_ifs.sv
src/mfc_ram.sv
src/mfc_front.sv
src/mfc_queue.sv
src/mfc_back.sv
src/multichannel_fir_convolver.sv
dv/testbench.sv
